// ----- rtl/colormap_grey_overlay_blend_top_defines.svh -----
// assertion macros used by the checker file
`ifndef COLORMAP_GREY_OVERLAY_BLEND_TOP_DEFINES_SVH
`define COLORMAP_GREY_OVERLAY_BLEND_TOP_DEFINES_SVH

// same-cycle implication, checked on every edge out of reset
`define CGOB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// next-cycle implication
`define CGOB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

// ----- rtl/cgob_pkg.sv -----
// shared types and constants of the colour-map overlay blender
package cgob_pkg;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    localparam int unsigned ADDR_W = 5;

    localparam logic [2:0] REG_PHASE_OFFSET = 3'd0;
    localparam logic [2:0] REG_PHASE_GAIN   = 3'd1;
    localparam logic [2:0] REG_AMP_OFFSET   = 3'd2;
    localparam logic [2:0] REG_AMP_GAIN     = 3'd3;
    localparam logic [2:0] REG_BLEND_WEIGHT = 3'd4;

    localparam logic [8:0] WEIGHT_RESET = 9'd102;
    localparam logic [8:0] WEIGHT_ONE   = 9'd256;

    typedef struct packed {
        logic [31:0] phase_offset;
        logic [31:0] phase_gain;
        logic [31:0] amp_offset;
        logic [31:0] amp_gain;
        logic [8:0]  blend_weight;
    } cfg_t;

    // load enables of the five pipeline stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } stage_en_t;

endpackage

// ----- rtl/cgob_regs.sv -----
// configuration register file with its bus port
module cgob_regs #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cgob_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output cgob_pkg::cfg_t               cfg
);

    localparam logic [31:0] GAIN_ONE = 32'(64'(1) << FRAC_BITS);

    cgob_pkg::cfg_t cfg_reg;
    logic [2:0]     reg_sel;
    logic           wr_en;

    assign reg_sel = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_offset <= 32'd0;
            cfg_reg.phase_gain   <= GAIN_ONE;
            cfg_reg.amp_offset   <= 32'd0;
            cfg_reg.amp_gain     <= GAIN_ONE;
            cfg_reg.blend_weight <= cgob_pkg::WEIGHT_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                cgob_pkg::REG_PHASE_OFFSET: cfg_reg.phase_offset <= pwdata;
                cgob_pkg::REG_PHASE_GAIN:   cfg_reg.phase_gain   <= pwdata;
                cgob_pkg::REG_AMP_OFFSET:   cfg_reg.amp_offset   <= pwdata;
                cgob_pkg::REG_AMP_GAIN:     cfg_reg.amp_gain     <= pwdata;
                cgob_pkg::REG_BLEND_WEIGHT: cfg_reg.blend_weight <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            cgob_pkg::REG_PHASE_OFFSET: prdata = cfg_reg.phase_offset;
            cgob_pkg::REG_PHASE_GAIN:   prdata = cfg_reg.phase_gain;
            cgob_pkg::REG_AMP_OFFSET:   prdata = cfg_reg.amp_offset;
            cgob_pkg::REG_AMP_GAIN:     prdata = cfg_reg.amp_gain;
            cgob_pkg::REG_BLEND_WEIGHT: prdata = {23'd0, cfg_reg.blend_weight};
            default:                    prdata = 32'd0;
        endcase
    end

endmodule

// ----- rtl/cgob_scale.sv -----
// three-stage sample to byte scaler: offset, gain multiply, round and clamp
module cgob_scale #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  cgob_pkg::stage_en_t  en,
    input  logic [31:0]          sample,
    input  logic [31:0]          offset,
    input  logic [31:0]          gain,
    output logic [7:0]           byte_val
);

    localparam int unsigned SHIFT = 2 * FRAC_BITS;
    localparam logic [64:0] HALF  = 65'(1) << (SHIFT - 1);
    localparam logic [63:0] LIMIT = 64'(509) << (SHIFT - 1);

    logic [32:0] diff;
    logic [32:0] diff_reg;
    logic        skip1_reg;
    logic [63:0] prod_reg;
    logic        skip2_reg;
    logic [64:0] rounded;
    logic [7:0]  byte_next;
    logic [7:0]  byte_reg;

    assign diff = {sample[31], sample} - {offset[31], offset};

    always_comb
    begin
        rounded = {1'b0, prod_reg} + HALF;
        if (skip2_reg)
            byte_next = 8'd0;
        else if (prod_reg >= LIMIT)
            byte_next = 8'd255;
        else
            byte_next = rounded[SHIFT+7:SHIFT];
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            diff_reg  <= diff;
            // raw zero or negative distance from the window minimum
            skip1_reg <= (sample == 32'd0) || diff[32];
        end
        if (en.s2)
        begin
            prod_reg  <= 64'(diff_reg[31:0]) * 64'(gain);
            skip2_reg <= skip1_reg;
        end
        if (en.s3)
            byte_reg <= byte_next;
    end

    assign byte_val = byte_reg;

endmodule

// ----- rtl/cgob_blend.sv -----
// colour table memory and the weighted colour / grey mix
module cgob_blend (
    input  logic                 clk,
    input  cgob_pkg::stage_en_t  en,
    input  logic                 wr_en,
    input  logic [7:0]           wr_idx,
    input  logic [23:0]          wr_colour,
    input  logic                 rd_en,
    input  logic [7:0]           rd_idx,
    input  logic [7:0]           grey,
    input  logic [8:0]           weight,
    output logic [15:0]          red_out,
    output logic [15:0]          green_out,
    output logic [15:0]          blue_out
);

    logic [23:0] table_mem [256];
    logic [23:0] rgb_reg;
    logic [7:0]  grey_reg;
    logic [8:0]  w;
    logic [8:0]  gw;
    logic [15:0] gpart;
    logic [15:0] red_reg;
    logic [15:0] green_reg;
    logic [15:0] blue_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            table_mem[wr_idx] <= wr_colour;
        if (rd_en)
            rgb_reg <= table_mem[rd_idx];
        if (en.s4)
            grey_reg <= grey;
    end

    always_comb
    begin
        // weights above one saturate to colour only
        w     = weight[8] ? cgob_pkg::WEIGHT_ONE : weight;
        gw    = cgob_pkg::WEIGHT_ONE - w;
        gpart = 16'(grey_reg) * 16'(gw);
    end

    always_ff @(posedge clk)
    begin
        if (en.s5)
        begin
            red_reg   <= 16'(rgb_reg[23:16]) * 16'(w) + gpart;
            green_reg <= 16'(rgb_reg[15:8]) * 16'(w) + gpart;
            blue_reg  <= 16'(rgb_reg[7:0]) * 16'(w) + gpart;
        end
    end

    assign red_out   = red_reg;
    assign green_out = green_reg;
    assign blue_out  = blue_reg;

endmodule

// ----- rtl/colormap_grey_overlay_blend_top.sv -----
// top level of the colour-map overlay blender
// One item, load or pixel, is taken per clock while req_stall is low, with five register
// stages: offset subtract, 32x32 gain multiply, round and clamp, colour table read, blend
// multiply-add. A pixel's result is offered on rsp_valid once it reaches the fifth stage;
// load items write the table as they leave the third stage and give no result. A stall
// on the result side holds the whole pipeline only where it is full, so bubbles are
// squeezed out. The table holds garbage after reset until loaded.
module colormap_grey_overlay_blend_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cgob_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  logic                         req_type,
    input  logic signed [31:0]           phase_sample,
    input  logic signed [31:0]           amp_sample,
    input  logic [7:0]                   table_index,
    input  logic [23:0]                  table_colour,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output logic [15:0]                  red_out,
    output logic [15:0]                  green_out,
    output logic [15:0]                  blue_out
);

    cgob_pkg::cfg_t      cfg;
    cgob_pkg::stage_en_t en;

    logic [4:0]  valid_reg;
    logic [4:0]  valid_next;
    logic [2:0]  type_reg;
    logic [7:0]  idx1_reg, idx2_reg, idx3_reg;
    logic [23:0] col1_reg, col2_reg, col3_reg;
    logic [7:0]  phase_byte;
    logic [7:0]  grey_byte;
    logic        tbl_wr;
    logic        tbl_rd;

    // a stage loads when it is empty or its occupant moves on
    always_comb
    begin
        en.s5 = !valid_reg[4] || !rsp_stall;
        en.s4 = !valid_reg[3] || en.s5;
        en.s3 = !valid_reg[2] || en.s4;
        en.s2 = !valid_reg[1] || en.s3;
        en.s1 = !valid_reg[0] || en.s2;

        valid_next[0] = en.s1 ? req_valid : valid_reg[0];
        valid_next[1] = en.s2 ? valid_reg[0] : valid_reg[1];
        valid_next[2] = en.s3 ? valid_reg[1] : valid_reg[2];
        // load beats end at the table and drop out here
        valid_next[3] = en.s4 ? (valid_reg[2] && type_reg[2] == cgob_pkg::REQ_PIXEL)
                              : valid_reg[3];
        valid_next[4] = en.s5 ? valid_reg[3] : valid_reg[4];

        tbl_wr = en.s4 && valid_reg[2] && type_reg[2] == cgob_pkg::REQ_LOAD;
        tbl_rd = en.s4 && valid_reg[2] && type_reg[2] == cgob_pkg::REQ_PIXEL;
    end

    assign req_stall = !en.s1;
    assign rsp_valid = valid_reg[4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 5'd0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            type_reg[0] <= req_type;
            idx1_reg    <= table_index;
            col1_reg    <= table_colour;
        end
        if (en.s2)
        begin
            type_reg[1] <= type_reg[0];
            idx2_reg    <= idx1_reg;
            col2_reg    <= col1_reg;
        end
        if (en.s3)
        begin
            type_reg[2] <= type_reg[1];
            idx3_reg    <= idx2_reg;
            col3_reg    <= col2_reg;
        end
    end

    cgob_regs #(
        .FRAC_BITS (FRAC_BITS)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cgob_scale #(
        .FRAC_BITS (FRAC_BITS)
    ) u_phase_scale (
        .clk      (clk),
        .en       (en),
        .sample   (phase_sample),
        .offset   (cfg.phase_offset),
        .gain     (cfg.phase_gain),
        .byte_val (phase_byte)
    );

    cgob_scale #(
        .FRAC_BITS (FRAC_BITS)
    ) u_amp_scale (
        .clk      (clk),
        .en       (en),
        .sample   (amp_sample),
        .offset   (cfg.amp_offset),
        .gain     (cfg.amp_gain),
        .byte_val (grey_byte)
    );

    cgob_blend u_blend (
        .clk       (clk),
        .en        (en),
        .wr_en     (tbl_wr),
        .wr_idx    (idx3_reg),
        .wr_colour (col3_reg),
        .rd_en     (tbl_rd),
        .rd_idx    (phase_byte),
        .grey      (grey_byte),
        .weight    (cfg.blend_weight),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out)
    );

endmodule

// ----- rtl/cgob_checker.sv -----
// port-level checks of the overlay blender and their bind
`include "colormap_grey_overlay_blend_top_defines.svh"

module cgob_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_stall,
    input logic        rsp_valid,
    input logic        rsp_stall,
    input logic [15:0] red_out,
    input logic [15:0] green_out,
    input logic [15:0] blue_out
);

    // a held result beat stays offered
    `CGOB_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)

    // a held result beat keeps its value
    `CGOB_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall,
        $stable(red_out) && $stable(green_out) && $stable(blue_out))

    // with no result waiting the pipeline can always move, so input is never held
    `CGOB_ASSERT_NOW(a_no_idle_stall, !rsp_valid, !req_stall)

    // blended channels never pass full colour at full weight
    `CGOB_ASSERT_NOW(a_rsp_range, rsp_valid,
        red_out <= 16'd65280 && green_out <= 16'd65280 && blue_out <= 16'd65280)

endmodule

bind colormap_grey_overlay_blend_top cgob_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out)
);

// ----- tb/testbench.sv -----
// self-checking testbench for the colour-map overlay blender top level
`timescale 1ns / 100ps

module testbench;

    localparam int FRAC_BITS   = 16;
    localparam int SETTLE      = 10;
    localparam int CYCLE_LIMIT = 400000;
    // 254.5 expressed in half units
    localparam logic [63:0] SAT_HALVES = 64'd509;

    typedef struct {
        logic        kind;
        logic [31:0] phase;
        logic [31:0] amp;
        logic [7:0]  lut_idx;
        logic [23:0] colour;
    } pixel_req_t;

    typedef struct {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } rgb_out_t;

    typedef enum int {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [cgob_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata       = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        req_valid    = 1'b0;
    logic        req_stall;
    logic        req_type     = cgob_pkg::REQ_LOAD;
    logic [31:0] phase_sample = '0;
    logic [31:0] amp_sample   = '0;
    logic [7:0]  table_index  = '0;
    logic [23:0] table_colour = '0;
    logic        rsp_valid;
    logic        rsp_stall    = 1'b0;
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;

    cgob_pkg::cfg_t blend_cfg = '{32'd0, 32'h0001_0000, 32'd0, 32'h0001_0000,
                                  cgob_pkg::WEIGHT_RESET};
    logic [23:0] colour_lut [256];
    bit          lut_loaded [256];
    rgb_out_t    expected_pixels [$];

    // sample windows used to aim random samples at the scaled range
    longint ph_lo = 0, ph_span = 256 << 16, am_lo = 0, am_span = 256 << 16;

    int fails = 0, n_pixels = 0, n_loads = 0, n_checked = 0, n_writes = 0;
    int cycle_count = 0;
    int hold_left = 0, seg_left = 0;
    rx_mode_t stall_mode = RX_FLOW;

    colormap_grey_overlay_blend_top #(.FRAC_BITS(FRAC_BITS)) dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
        .phase_sample(phase_sample), .amp_sample(amp_sample),
        .table_index(table_index), .table_colour(table_colour),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
        .red_out(red_out), .green_out(green_out), .blue_out(blue_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("testbench NOT OK");
            $finish;
        end
    end

    // ---------------- prediction ----------------

    function automatic logic [7:0] scale_to_byte(logic [31:0] raw, logic [31:0] offset,
                                                 logic [31:0] gain);
        logic signed [63:0] diff;
        logic [63:0]        prod;
        diff = $signed({{32{raw[31]}}, raw}) - $signed({{32{offset[31]}}, offset});
        if (raw == '0 || diff < 0)
            return 8'd0;
        prod = $unsigned(diff) * {32'd0, gain};
        if (prod >= (SAT_HALVES << (2 * FRAC_BITS - 1)))
            return 8'd255;
        prod = (prod + (64'd1 << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
        return prod[7:0];
    endfunction

    function automatic rgb_out_t blend_pixel(logic [31:0] phase, logic [31:0] amp);
        logic [7:0]  grey;
        logic [23:0] rgb;
        logic [8:0]  w;
        logic [15:0] grey_part;
        rgb_out_t    px;
        rgb = colour_lut[scale_to_byte(phase, blend_cfg.phase_offset, blend_cfg.phase_gain)];
        grey = scale_to_byte(amp, blend_cfg.amp_offset, blend_cfg.amp_gain);
        w = (blend_cfg.blend_weight > cgob_pkg::WEIGHT_ONE) ? cgob_pkg::WEIGHT_ONE
                                                              : blend_cfg.blend_weight;
        grey_part = grey * (cgob_pkg::WEIGHT_ONE - w);
        px.red   = rgb[23:16] * w + grey_part;
        px.green = rgb[15:8] * w + grey_part;
        px.blue  = rgb[7:0] * w + grey_part;
        return px;
    endfunction

    // ---------------- result checking ----------------

    function automatic void compare_channel(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        rgb_out_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("unexpected result beat: red %0d green %0d blue %0d",
                       red_out, green_out, blue_out);
                fails++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                compare_channel("red_out", want.red, red_out);
                compare_channel("green_out", want.green, green_out);
                compare_channel("blue_out", want.blue, blue_out);
                n_checked++;
            end
        end
    end

    // receiver: long holds on request, otherwise segments of differing stall density
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else
        begin
            if (seg_left == 0)
            begin
                stall_mode = rx_mode_t'($urandom_range(0, 3));
                seg_left = $urandom_range(1, 40);
            end
            seg_left = seg_left - 1;
            case (stall_mode)
                RX_FLOW:  rsp_stall <= 1'b0;
                RX_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
                RX_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
                default:  rsp_stall <= ~rsp_stall;
            endcase
        end
    end

    // ---------------- drivers ----------------

    task automatic send_item(input pixel_req_t it);
        req_valid    <= 1'b1;
        req_type     <= it.kind;
        phase_sample <= it.phase;
        amp_sample   <= it.amp;
        table_index  <= it.lut_idx;
        table_colour <= it.colour;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (it.kind == cgob_pkg::REQ_LOAD)
        begin
            colour_lut[it.lut_idx] = it.colour;
            lut_loaded[it.lut_idx] = 1'b1;
            n_loads++;
        end
        else
        begin
            expected_pixels.push_back(blend_pixel(it.phase, it.amp));
            n_pixels++;
        end
    endtask

    task automatic send_load(input logic [7:0] idx, input logic [23:0] colour);
        pixel_req_t it;
        it.kind    = cgob_pkg::REQ_LOAD;
        it.phase   = $urandom;
        it.amp     = $urandom;
        it.lut_idx = idx;
        it.colour  = colour;
        send_item(it);
    endtask

    // loads the addressed table entry first if it was never written
    task automatic send_pixel(input logic [31:0] phase, input logic [31:0] amp);
        logic [7:0] idx;
        pixel_req_t it;
        idx = scale_to_byte(phase, blend_cfg.phase_offset, blend_cfg.phase_gain);
        if (!lut_loaded[idx])
            send_load(idx, 24'($urandom));
        it.kind    = cgob_pkg::REQ_PIXEL;
        it.phase   = phase;
        it.amp     = amp;
        it.lut_idx = 8'($urandom);
        it.colour  = 24'($urandom);
        send_item(it);
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0)
        begin
            req_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_results_drained();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_pixels.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [2:0] regsel, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {regsel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (regsel)
            cgob_pkg::REG_PHASE_OFFSET: blend_cfg.phase_offset = value;
            cgob_pkg::REG_PHASE_GAIN:   blend_cfg.phase_gain   = value;
            cgob_pkg::REG_AMP_OFFSET:   blend_cfg.amp_offset   = value;
            cgob_pkg::REG_AMP_GAIN:     blend_cfg.amp_gain     = value;
            cgob_pkg::REG_BLEND_WEIGHT: blend_cfg.blend_weight = value[8:0];
            default: ;
        endcase
        n_writes++;
        @(posedge clk);
    endtask

    function automatic logic [31:0] random_sample(longint lo, longint span);
        longint off;
        off = longint'($urandom) % span;
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1:
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'hFFFF_FFFF;
                    default: return 32'd1;
                endcase
            2: return $urandom;
            3: return 32'(lo + longint'($urandom_range(0, 4)) - 2);
            4: return 32'(lo + span + longint'($urandom_range(0, 4)) - 2);
            default: return 32'(lo + off);
        endcase
    endfunction

    // gain that maps a window of span raw units onto 0..255
    function automatic logic [31:0] gain_for(longint span);
        logic [63:0] g;
        g = (64'd255 << 32) / 64'(span);
        return g[31:0];
    endfunction

    task automatic apply_setting(input int setting);
        logic [8:0] weight;
        wait_results_drained();
        case (setting % 5)
            0:
            begin
                // phase window of one turn around zero, amplitude 0..1000
                ph_lo = -205887; ph_span = 411775;
                am_lo = 0;       am_span = 1000 << 16;
                weight = 9'($urandom_range(0, 256));
            end
            1:
            begin
                ph_lo = longint'(-2147483647 - 1); ph_span = 256;
                am_lo = 2147483647 - 256; am_span = 256;
                weight = 9'd511;
            end
            2:
            begin
                ph_lo = longint'(int'($urandom));
                ph_span = 256 + longint'($urandom_range(0, 32'h7FFF_FF00));
                am_lo = longint'(int'($urandom));
                am_span = 256 + longint'($urandom_range(0, 32'h7FFF_FF00));
                weight = 9'($urandom_range(0, 511));
            end
            3:
            begin
                ph_lo = longint'(int'($urandom));
                ph_span = longint'($urandom_range(256, 4096));
                am_lo = longint'(int'($urandom));
                am_span = longint'($urandom_range(256, 4096));
                weight = cgob_pkg::WEIGHT_ONE;
            end
            default:
            begin
                ph_lo = longint'($urandom_range(0, 1 << 20)) - longint'(1 << 19);
                ph_span = 255 << 16;
                am_lo = longint'($urandom_range(0, 1 << 20)) - longint'(1 << 19);
                am_span = 255 << 16;
                weight = 9'($urandom_range(257, 511));
            end
        endcase
        cfg_write(cgob_pkg::REG_PHASE_OFFSET, 32'(ph_lo));
        cfg_write(cgob_pkg::REG_AMP_OFFSET, 32'(am_lo));
        if (setting % 5 == 1)
        begin
            cfg_write(cgob_pkg::REG_PHASE_GAIN, 32'hFFFF_FFFF);
            cfg_write(cgob_pkg::REG_AMP_GAIN, 32'd0);
        end
        else
        begin
            cfg_write(cgob_pkg::REG_PHASE_GAIN, gain_for(ph_span));
            cfg_write(cgob_pkg::REG_AMP_GAIN, gain_for(am_span));
        end
        cfg_write(cgob_pkg::REG_BLEND_WEIGHT, {23'd0, weight});
    endtask

    task automatic run_bursts(input int count);
        int burst;
        while (count > 0)
        begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && count > 0)
            begin
                if ($urandom_range(0, 7) == 0)
                    send_load(8'($urandom), 24'($urandom));
                else
                    send_pixel(random_sample(ph_lo, ph_span), random_sample(am_lo, am_span));
                burst--;
                count--;
            end
            idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
        end
    endtask

    // ---------------- tests ----------------

    // reset window: gain 1.0 and zero offset, so bytes follow the sample directly
    task automatic test_scaling_edges();
        send_load(8'd0, 24'hFF_FFFF);
        send_load(8'd255, 24'h00_0000);
        send_load(8'd128, 24'hA5_5A0F);
        send_pixel(32'd0, 32'd0);
        send_pixel(32'hFFFF_FFFF, 32'h8000_0000);
        send_pixel(32'd1, 32'h0000_7FFF);
        send_pixel(32'h007F_8000, 32'h007F_7FFF);
        send_pixel(32'h00FE_8000, 32'h00FE_7FFF);
        send_pixel(32'h7FFF_FFFF, 32'h00FF_0000);
        wait_results_drained();
    endtask

    task automatic test_extreme_registers();
        logic [8:0] weights [4];
        weights = '{9'd0, 9'd256, 9'd257, 9'd511};
        cfg_write(cgob_pkg::REG_PHASE_OFFSET, 32'h8000_0000);
        cfg_write(cgob_pkg::REG_PHASE_GAIN, 32'hFFFF_FFFF);
        cfg_write(cgob_pkg::REG_AMP_OFFSET, 32'h8000_0000);
        cfg_write(cgob_pkg::REG_AMP_GAIN, 32'd0);
        send_pixel(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_pixel(32'h8000_0000, 32'h0000_1234);
        send_pixel(32'd0, 32'hFFFF_FFFF);
        send_pixel(32'h8000_0080, 32'h8000_0000);
        foreach (weights[i])
        begin
            wait_results_drained();
            cfg_write(cgob_pkg::REG_BLEND_WEIGHT, {23'd0, weights[i]});
            cfg_write(cgob_pkg::REG_AMP_GAIN, 32'h0001_0000);
            send_pixel(32'h8000_0040, 32'h8000_0000 + 32'($urandom_range(0, 32'h01FF_FFFF)));
        end
        wait_results_drained();
    endtask

    // output held off long enough for the pipeline to fill and stall its input
    task automatic test_output_backpressure();
        hold_left = 300;
        repeat (60)
            send_pixel(random_sample(ph_lo, ph_span), random_sample(am_lo, am_span));
        wait_results_drained();
    endtask

    task automatic test_random_traffic();
        for (int s = 0; s < 6; s++)
        begin
            apply_setting(s);
            run_bursts(140);
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_scaling_edges();
        test_extreme_registers();
        test_output_backpressure();
        test_random_traffic();
        wait_results_drained();
        $display("covered %0d pixels and %0d table loads across %0d register writes",
                 n_pixels, n_loads, n_writes);
        $display("%0d blended results compared, %0d failures", n_checked, fails);
        if (fails == 0 && expected_pixels.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
